// ----- hdl/tct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types and constants for the text console teletype engine.
// ----------------------------------------------------------------------------
package tct_pkg;

    // request codes on req_type
    typedef enum logic [1:0] {
        REQ_PUT    = 2'd0,
        REQ_READ   = 2'd1,
        REQ_COLORS = 2'd2,
        REQ_CURSOR = 2'd3
    } req_t;

    // control characters handled by a put request
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0]  BLANK_ATTR = 8'h0F;
    localparam logic [15:0] BLANK_CELL = {BLANK_ATTR, CH_SPACE};

    // fixed port widths
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;
    localparam int POS_OUT_W  = 11;
    localparam int CELL_W     = 16;

    typedef enum logic {
        SWEEP_CLEAR  = 1'b0,
        SWEEP_SCROLL = 1'b1
    } sweep_mode_t;

    // command from the request sequencer to the sweep engine
    typedef struct packed {
        logic              start;
        sweep_mode_t       mode;
        logic [CELL_W-1:0] fill;
    } sweep_cmd_t;

endpackage

// ----- hdl/text_console_teletype.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_teletype
// Text-mode console engine: put character with control codes, scroll and
// clear over a cell memory, colour and cursor control, cell read back.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// request | in        | in_valid/in_stall  | req_type char_code fg_color
//         |           |                    | bg_color cursor_row_in
//         |           |                    | cursor_col_in cell_address
// result  | out       | out_valid/out_stall| cursor_row cursor_col
//         |           |                    | cursor_position cell_data
//
// a read passes through an extra state while the registered memory read completes
// a scroll and a form feed are carried out by the sweep engine walking the
// cell memory, with its one write and one read port, one cell per cycle
// after reset a blanking pass over every cell runs before the first request
// a result waits in the output register under out_stall; the next request is
// still taken and held in its last step until the register frees
// ----------------------------------------------------------------------------
module text_console_teletype #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  char_code,
    input  logic [3:0]  fg_color,
    input  logic [3:0]  bg_color,
    input  logic [7:0]  cursor_row_in,
    input  logic [7:0]  cursor_col_in,
    input  logic [10:0] cell_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  cursor_row,
    output logic [6:0]  cursor_col,
    output logic [10:0] cursor_position,
    output logic [15:0] cell_data
);
    import tct_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);

    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_SWEEP = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [7:0]        attr_reg, attr_next;
    logic [CELL_W-1:0] data_reg, data_next;
    logic              out_valid_reg, out_valid_next;
    logic [4:0]        out_row_reg;
    logic [6:0]        out_col_reg;
    logic [10:0]       out_pos_reg;
    logic [15:0]       out_data_reg;
    logic              out_load;

    logic [AW-1:0]     pos;
    logic              accept;
    sweep_cmd_t        sw_cmd;
    logic              sw_busy;
    logic              sw_we, sw_re;
    logic [AW-1:0]     sw_waddr, sw_raddr;
    logic [15:0]       sw_wdata;
    logic              top_we, top_re;
    logic [AW-1:0]     top_raddr;
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [15:0]       ram_wdata, ram_rdata;

    assign pos    = AW'(row_reg) * AW'(COLS) + AW'(col_reg);
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        attr_next      = attr_reg;
        data_next      = data_reg;
        sw_cmd.start   = 1'b0;
        sw_cmd.mode    = SWEEP_SCROLL;
        sw_cmd.fill    = {attr_reg, CH_SPACE};
        top_we         = 1'b0;
        top_re         = 1'b0;
        top_raddr      = AW'(cell_address);
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_INIT:
            begin
                if (!sw_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    data_next  = '0;
                    state_next = ST_DONE;
                    case (req_t'(req_type))
                        REQ_PUT:
                        begin
                            case (char_code)
                                CH_LF:
                                begin
                                    col_next = '0;
                                    if (row_reg == RW'(ROWS - 1))
                                    begin
                                        sw_cmd.start = 1'b1;
                                        state_next   = ST_SWEEP;
                                    end
                                    else
                                    begin
                                        row_next = row_reg + 1'b1;
                                    end
                                end
                                CH_CR:
                                begin
                                    col_next = '0;
                                end
                                CH_BS:
                                begin
                                    if (col_reg != '0)
                                    begin
                                        col_next = col_reg - 1'b1;
                                    end
                                end
                                CH_FF:
                                begin
                                    attr_next    = BLANK_ATTR;
                                    row_next     = '0;
                                    col_next     = '0;
                                    sw_cmd.start = 1'b1;
                                    sw_cmd.mode  = SWEEP_CLEAR;
                                    sw_cmd.fill  = BLANK_CELL;
                                    state_next   = ST_SWEEP;
                                end
                                default:
                                begin
                                    top_we = 1'b1;
                                    if (col_reg == CW'(COLS - 1))
                                    begin
                                        col_next = '0;
                                        if (row_reg == RW'(ROWS - 1))
                                        begin
                                            sw_cmd.start = 1'b1;
                                            state_next   = ST_SWEEP;
                                        end
                                        else
                                        begin
                                            row_next = row_reg + 1'b1;
                                        end
                                    end
                                    else
                                    begin
                                        col_next = col_reg + 1'b1;
                                    end
                                end
                            endcase
                        end
                        REQ_READ:
                        begin
                            // out of range addresses read back as zero
                            if (32'(cell_address) < CELLS)
                            begin
                                top_re     = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        REQ_COLORS:
                        begin
                            attr_next = {bg_color, fg_color};
                        end
                        REQ_CURSOR:
                        begin
                            if (32'(cursor_row_in) >= ROWS)
                            begin
                                row_next = RW'(ROWS - 1);
                            end
                            else
                            begin
                                row_next = RW'(cursor_row_in);
                            end
                            if (32'(cursor_col_in) >= COLS)
                            begin
                                col_next = CW'(COLS - 1);
                            end
                            else
                            begin
                                col_next = CW'(cursor_col_in);
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                data_next  = ram_rdata;
                state_next = ST_DONE;
            end
            ST_SWEEP:
            begin
                if (!sw_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            row_reg       <= '0;
            col_reg       <= '0;
            attr_reg      <= BLANK_ATTR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            attr_reg      <= attr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (out_load)
        begin
            out_row_reg  <= ROW_OUT_W'(row_reg);
            out_col_reg  <= COL_OUT_W'(col_reg);
            out_pos_reg  <= POS_OUT_W'(pos);
            out_data_reg <= data_reg;
        end
    end

    // sweep engine owns the memory while busy, the sequencer otherwise
    assign ram_we    = sw_we | top_we;
    assign ram_waddr = sw_we ? sw_waddr : pos;
    assign ram_wdata = sw_we ? sw_wdata : {attr_reg, char_code};
    assign ram_re    = sw_re | top_re;
    assign ram_raddr = sw_re ? sw_raddr : top_raddr;

    tct_sweep #(
        .COLS (COLS),
        .ROWS (ROWS),
        .AW   (AW)
    ) u_sweep (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (sw_cmd),
        .busy  (sw_busy),
        .we    (sw_we),
        .waddr (sw_waddr),
        .wdata (sw_wdata),
        .re    (sw_re),
        .raddr (sw_raddr),
        .rdata (ram_rdata)
    );

    tct_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall        = (state_reg != ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign cursor_row      = out_row_reg;
    assign cursor_col      = out_col_reg;
    assign cursor_position = out_pos_reg;
    assign cell_data       = out_data_reg;

endmodule

// ----- hdl/tct_cell_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_cell_ram
// Single write, single registered read port cell memory.
// ----------------------------------------------------------------------------
module tct_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);
    import tct_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/tct_sweep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_sweep
// Address sequencer that walks the cell memory one cell a cycle, either
// filling every cell or scrolling up one row and blanking the last row.
// ----------------------------------------------------------------------------
module tct_sweep #(
    parameter int COLS = 80,
    parameter int ROWS = 25,
    parameter int AW   = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tct_pkg::sweep_cmd_t cmd,
    output logic                busy,
    output logic                we,
    output logic [AW-1:0]       waddr,
    output logic [15:0]         wdata,
    output logic                re,
    output logic [AW-1:0]       raddr,
    input  logic [15:0]         rdata
);
    import tct_pkg::*;

    localparam int CELLS     = ROWS * COLS;
    localparam int LAST_COPY = CELLS - COLS - 1;

    typedef enum logic [3:0] {
        SW_IDLE  = 4'b0001,
        SW_PRIME = 4'b0010,
        SW_COPY  = 4'b0100,
        SW_FILL  = 4'b1000
    } sw_state_t;

    sw_state_t         state_reg, state_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic [CELL_W-1:0] fill_reg, fill_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        fill_next  = fill_reg;
        we         = 1'b0;
        waddr      = cnt_reg;
        wdata      = fill_reg;
        re         = 1'b0;
        raddr      = cnt_reg + AW'(COLS + 1);
        case (state_reg)
            SW_IDLE:
            begin
                if (cmd.start)
                begin
                    fill_next = cmd.fill;
                    cnt_next  = '0;
                    if (cmd.mode == SWEEP_SCROLL)
                    begin
                        state_next = SW_PRIME;
                    end
                    else
                    begin
                        state_next = SW_FILL;
                    end
                end
            end
            SW_PRIME:
            begin
                // first read one row down, data arrives next cycle
                re         = 1'b1;
                raddr      = AW'(COLS);
                state_next = SW_COPY;
            end
            SW_COPY:
            begin
                we       = 1'b1;
                wdata    = rdata;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == AW'(LAST_COPY))
                begin
                    state_next = SW_FILL;
                end
                else
                begin
                    re = 1'b1;
                end
            end
            SW_FILL:
            begin
                we = 1'b1;
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    state_next = SW_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = SW_IDLE;
            end
        endcase
    end

    // reset starts a blanking pass over the whole screen
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SW_FILL;
            cnt_reg   <= '0;
            fill_reg  <= BLANK_CELL;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fill_reg  <= fill_next;
        end
    end

    assign busy = (state_reg != SW_IDLE);

endmodule

// ----- hdl/tct_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_checker
// Port level checks for the text console teletype, bound to the top level.
// ----------------------------------------------------------------------------
module tct_checker #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [4:0]  cursor_row,
    input logic [6:0]  cursor_col,
    input logic [10:0] cursor_position,
    input logic [15:0] cell_data
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cursor_row)
            && $stable(cursor_col) && $stable(cursor_position) && $stable(cell_data))
    else $error("stalled result changed");

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

    // cursor inside the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(cursor_col) < COLS) && (32'(cursor_row) < ROWS))
    else $error("cursor off screen");

    // linear position agrees with row and column
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (ROWS <= 32) |->
            cursor_position == 11'(32'(cursor_row) * COLS + 32'(cursor_col)))
    else $error("cursor position mismatch");

endmodule

bind text_console_teletype tct_checker #(
    .COLS (COLS),
    .ROWS (ROWS)
) u_tct_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cursor_row      (cursor_row),
    .cursor_col      (cursor_col),
    .cursor_position (cursor_position),
    .cell_data       (cell_data)
);
